// File: hw/rtl/ctcgd_pkg.sv
// ----------------------------------------------------------------------------
// ctcgd_pkg
// Shared types and constants of the CTC greedy decoder.
// ----------------------------------------------------------------------------
package ctcgd_pkg;

  localparam logic [16:0] ONE_Q16 = 17'h10000;

  localparam int RegIdxW = 2;
  localparam logic [RegIdxW-1:0] REG_BLANK_INDEX    = 2'd0;
  localparam logic [RegIdxW-1:0] REG_CONF_THRESHOLD = 2'd1;
  localparam logic [RegIdxW-1:0] REG_USE_CONFIDENCE = 2'd2;

  localparam logic [7:0]  BLANK_RESET = 8'd32;
  localparam logic [16:0] THR_RESET   = 17'd0;
  localparam logic        USE_RESET   = 1'b1;

  localparam logic KIND_CHAR    = 1'b0;
  localparam logic KIND_SUMMARY = 1'b1;

  typedef struct packed {
    logic [7:0]  blank_index;
    logic [16:0] conf_threshold;
    logic        use_confidence;
  } cfg_t;

  // one queue entry: an optional character and an optional summary request
  typedef struct packed {
    logic        has_char;
    logic        last;
    logic [7:0]  idx;
    logic [16:0] conf;
  } cmd_t;

endpackage

// File: hw/rtl/ctc_greedy_decoder_top.sv
// ----------------------------------------------------------------------------
// ctc_greedy_decoder_top
// CTC greedy decoder: drops blanks and repeats, thresholds confidences,
// emits characters and a per-sequence count and mean confidence.
// ----------------------------------------------------------------------------
// The front end takes one timestep per cycle while its four-entry work queue
// has room. The back end fetches each queue entry before it loads the output
// register, so it does not take a new entry until it is through with the last;
// a final timestep then runs a bit-serial divider on the SumW-bit sum before
// the summary is loaded, and a full output register stalls both loads.
// Registers: blank_index at 0x0, conf_threshold at 0x4,
// use_confidence at 0x8; write them only while the block is idle.
// ----------------------------------------------------------------------------
module ctc_greedy_decoder_top import ctcgd_pkg::*; #(
  parameter int MAX_STEPS = 32,
  localparam int CntW = $clog2(MAX_STEPS + 1),
  localparam int SumW = 16 + CntW
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [3:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  input  logic              push_i,
  output logic              full_o,
  input  logic signed [8:0] class_index_i,
  input  logic [16:0]       confidence_i,
  input  logic              final_step_i,
  output logic              empty_o,
  input  logic              pop_i,
  output logic              kind_o,
  output logic [7:0]        char_index_o,
  output logic [16:0]       char_conf_o,
  output logic [CntW-1:0]   char_count_o,
  output logic [16:0]       mean_conf_o,
  output logic              run_end_o
);

  localparam int EntW = $bits(cmd_t) + SumW + CntW;

  cfg_t              cfg_q;
  logic              cfg_wr;
  logic [RegIdxW-1:0] reg_idx;

  logic              q_wr, q_full, q_rd, q_empty;
  cmd_t              wr_cmd, rd_cmd;
  logic [SumW-1:0]   wr_sum, rd_sum;
  logic [CntW-1:0]   wr_cnt, rd_cnt;

  assign pready  = 1'b1;
  assign cfg_wr  = psel & penable & pwrite;
  assign reg_idx = paddr[3:2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.blank_index    <= BLANK_RESET;
      cfg_q.conf_threshold <= THR_RESET;
      cfg_q.use_confidence <= USE_RESET;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        REG_BLANK_INDEX:    cfg_q.blank_index    <= pwdata[7:0];
        REG_CONF_THRESHOLD: cfg_q.conf_threshold <= pwdata[16:0];
        REG_USE_CONFIDENCE: cfg_q.use_confidence <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_BLANK_INDEX:    prdata = {24'd0, cfg_q.blank_index};
      REG_CONF_THRESHOLD: prdata = {15'd0, cfg_q.conf_threshold};
      REG_USE_CONFIDENCE: prdata = {31'd0, cfg_q.use_confidence};
      default:            prdata = '0;
    endcase
  end

  ctcgd_front #(
    .MaxSteps(MAX_STEPS)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .push_i       (push_i),
    .full_o       (full_o),
    .class_index_i(class_index_i),
    .confidence_i (confidence_i),
    .final_step_i (final_step_i),
    .q_full_i     (q_full),
    .q_wr_o       (q_wr),
    .q_cmd_o      (wr_cmd),
    .q_sum_o      (wr_sum),
    .q_cnt_o      (wr_cnt)
  );

  ctcgd_fifo #(
    .Width(EntW),
    .Depth(4)
  ) u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .wr_i   (q_wr),
    .wdata_i({wr_cmd, wr_sum, wr_cnt}),
    .full_o (q_full),
    .rd_i   (q_rd),
    .rdata_o({rd_cmd, rd_sum, rd_cnt}),
    .empty_o(q_empty)
  );

  ctcgd_back #(
    .MaxSteps(MAX_STEPS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_empty_i   (q_empty),
    .q_cmd_i     (rd_cmd),
    .q_sum_i     (rd_sum),
    .q_cnt_i     (rd_cnt),
    .q_rd_o      (q_rd),
    .empty_o     (empty_o),
    .pop_i       (pop_i),
    .kind_o      (kind_o),
    .char_index_o(char_index_o),
    .char_conf_o (char_conf_o),
    .char_count_o(char_count_o),
    .mean_conf_o (mean_conf_o),
    .run_end_o   (run_end_o)
  );

endmodule

// File: hw/rtl/ctcgd_front.sv
// ----------------------------------------------------------------------------
// ctcgd_front
// Classifies timesteps, tracks the previous index, sum and count, and queues
// character and summary work for the back end.
// ----------------------------------------------------------------------------
module ctcgd_front import ctcgd_pkg::*; #(
  parameter int MaxSteps = 32,
  localparam int CntW = $clog2(MaxSteps + 1),
  localparam int SumW = 16 + CntW
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  cfg_t                   cfg_i,
  input  logic                   push_i,
  output logic                   full_o,
  input  logic signed [8:0]      class_index_i,
  input  logic [16:0]            confidence_i,
  input  logic                   final_step_i,
  input  logic                   q_full_i,
  output logic                   q_wr_o,
  output cmd_t                   q_cmd_o,
  output logic [SumW-1:0]        q_sum_o,
  output logic [CntW-1:0]        q_cnt_o
);

  logic signed [8:0] prev_q, prev_d;
  logic [SumW-1:0]   sum_q, sum_d, sum_upd;
  logic [CntW-1:0]   cnt_q, cnt_d, cnt_upd;
  logic              accept, skip, new_char, have_char, room;
  logic [16:0]       conf_sel, conf_sat;

  assign accept   = push_i & ~q_full_i;
  assign full_o   = q_full_i;

  assign skip     = class_index_i[8] || (class_index_i[7:0] == cfg_i.blank_index);
  assign new_char = !skip && (class_index_i != prev_q);
  assign conf_sel = cfg_i.use_confidence ? confidence_i : ONE_Q16;
  assign conf_sat = (conf_sel > ONE_Q16) ? ONE_Q16 : conf_sel;
  assign have_char = new_char && (conf_sat >= cfg_i.conf_threshold);
  assign room     = cnt_q < CntW'(MaxSteps);

  assign sum_upd  = (have_char && room) ? sum_q + SumW'(conf_sat) : sum_q;
  assign cnt_upd  = (have_char && room) ? cnt_q + CntW'(1) : cnt_q;

  always_comb begin
    prev_d = prev_q;
    sum_d  = sum_q;
    cnt_d  = cnt_q;
    if (accept) begin
      if (final_step_i) begin
        prev_d = -9'sd1;
        sum_d  = '0;
        cnt_d  = '0;
      end else begin
        prev_d = class_index_i;
        sum_d  = sum_upd;
        cnt_d  = cnt_upd;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q <= -9'sd1;
      sum_q  <= '0;
      cnt_q  <= '0;
    end else begin
      prev_q <= prev_d;
      sum_q  <= sum_d;
      cnt_q  <= cnt_d;
    end
  end

  assign q_wr_o           = accept && (have_char || final_step_i);
  assign q_cmd_o.has_char = have_char;
  assign q_cmd_o.last     = final_step_i;
  assign q_cmd_o.idx      = class_index_i[7:0];
  assign q_cmd_o.conf     = conf_sat;
  assign q_sum_o          = sum_upd;
  assign q_cnt_o          = cnt_upd;

endmodule

// File: hw/rtl/ctcgd_fifo.sv
// ----------------------------------------------------------------------------
// ctcgd_fifo
// Small register queue between the front and back ends.
// ----------------------------------------------------------------------------
module ctcgd_fifo #(
  parameter int Width = 8,
  parameter int Depth = 4,
  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1,
  localparam int CntW = $clog2(Depth + 1)
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             wr_i,
  input  logic [Width-1:0] wdata_i,
  output logic             full_o,
  input  logic             rd_i,
  output logic [Width-1:0] rdata_o,
  output logic             empty_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [PtrW-1:0]  wptr_q, rptr_q;
  logic [CntW-1:0]  cnt_q;
  logic             do_wr, do_rd;

  assign full_o  = cnt_q == CntW'(Depth);
  assign empty_o = cnt_q == '0;
  assign do_wr   = wr_i & ~full_o;
  assign do_rd   = rd_i & ~empty_o;
  assign rdata_o = mem_q[rptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (do_wr) begin
        wptr_q <= (wptr_q == PtrW'(Depth - 1)) ? '0 : wptr_q + PtrW'(1);
      end
      if (do_rd) begin
        rptr_q <= (rptr_q == PtrW'(Depth - 1)) ? '0 : rptr_q + PtrW'(1);
      end
      if (do_wr && !do_rd) begin
        cnt_q <= cnt_q + CntW'(1);
      end else if (do_rd && !do_wr) begin
        cnt_q <= cnt_q - CntW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      mem_q[wptr_q] <= wdata_i;
    end
  end

endmodule

// File: hw/rtl/ctcgd_back.sv
// ----------------------------------------------------------------------------
// ctcgd_back
// Drains queued work: emits character results and computes the mean
// confidence with a one-bit-per-cycle restoring divider for the summary.
// ----------------------------------------------------------------------------
module ctcgd_back import ctcgd_pkg::*; #(
  parameter int MaxSteps = 32,
  localparam int CntW  = $clog2(MaxSteps + 1),
  localparam int SumW  = 16 + CntW,
  localparam int StepW = $clog2(SumW)
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             q_empty_i,
  input  cmd_t             q_cmd_i,
  input  logic [SumW-1:0]  q_sum_i,
  input  logic [CntW-1:0]  q_cnt_i,
  output logic             q_rd_o,
  output logic             empty_o,
  input  logic             pop_i,
  output logic             kind_o,
  output logic [7:0]       char_index_o,
  output logic [16:0]      char_conf_o,
  output logic [CntW-1:0]  char_count_o,
  output logic [16:0]      mean_conf_o,
  output logic             run_end_o
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_CHAR = 2'd1;
  localparam logic [1:0] ST_DIV  = 2'd2;
  localparam logic [1:0] ST_SUM  = 2'd3;

  logic [1:0]       state_q, state_d;
  cmd_t             cmd_q;
  logic [CntW-1:0]  cnt_q, rem_q, rem_d;
  logic [SumW-1:0]  dvd_q;
  logic [StepW-1:0] step_q;
  logic [CntW:0]    trial, diff;
  logic             ge, out_vld_q, out_free, load_char, load_sum;

  assign trial = {rem_q, dvd_q[SumW-1]};
  assign diff  = trial - {1'b0, cnt_q};
  assign ge    = trial >= {1'b0, cnt_q};
  assign rem_d = ge ? diff[CntW-1:0] : trial[CntW-1:0];

  assign out_free  = !out_vld_q || pop_i;
  assign q_rd_o    = (state_q == ST_IDLE) && !q_empty_i;
  assign load_char = (state_q == ST_CHAR) && out_free;
  assign load_sum  = (state_q == ST_SUM) && out_free;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: if (!q_empty_i) begin
        state_d = q_cmd_i.has_char ? ST_CHAR : ST_DIV;
      end
      ST_CHAR: if (out_free) begin
        state_d = cmd_q.last ? ST_DIV : ST_IDLE;
      end
      ST_DIV: if (step_q == '0) begin
        state_d = ST_SUM;
      end
      ST_SUM: if (out_free) begin
        state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      out_vld_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (load_char || load_sum) begin
        out_vld_q <= 1'b1;
      end else if (pop_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_rd_o) begin
      cmd_q  <= q_cmd_i;
      cnt_q  <= q_cnt_i;
      dvd_q  <= q_sum_i;
      rem_q  <= '0;
      step_q <= StepW'(SumW - 1);
    end else if (state_q == ST_DIV) begin
      dvd_q  <= {dvd_q[SumW-2:0], ge};
      rem_q  <= rem_d;
      step_q <= step_q - StepW'(1);
    end
    if (load_char) begin
      kind_o       <= KIND_CHAR;
      char_index_o <= cmd_q.idx;
      char_conf_o  <= cmd_q.conf;
      char_count_o <= '0;
      mean_conf_o  <= '0;
      run_end_o    <= !cmd_q.last;
    end else if (load_sum) begin
      kind_o       <= KIND_SUMMARY;
      char_index_o <= '0;
      char_conf_o  <= '0;
      char_count_o <= cnt_q;
      mean_conf_o  <= (cnt_q == '0) ? 17'd0 : dvd_q[16:0];
      run_end_o    <= 1'b1;
    end
  end

  assign empty_o = !out_vld_q;

endmodule
